/* sv/dprf_pkg.sv */
// Package: shared constants, reason codes and frame state type for the DNS reply filter.
package dprf_pkg;

    localparam int unsigned POS_W    = 16;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned PORT_W   = 16;
    localparam int unsigned CFG_W    = 32;

    localparam logic [ADDR_W-1:0] SRC_ADDR_RESET = 32'h0808_0808;
    localparam logic [PORT_W-1:0] DNS_PORT_RESET = 16'd53;

    // configuration register indexes
    localparam logic CFG_SRC_ADDR = 1'b0;
    localparam logic CFG_DNS_PORT = 1'b1;

    localparam logic [15:0] TYPE_IPV4    = 16'h0800;
    localparam logic [15:0] TYPE_IPV6    = 16'h86DD;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [15:0] FRAG_DF_ONLY = 16'h4000;

    // byte offsets within the frame
    localparam logic [POS_W-1:0] POS_TYPE_HI  = 16'd12;
    localparam logic [POS_W-1:0] POS_TYPE_LO  = 16'd13;
    localparam logic [POS_W-1:0] POS_IHL      = 16'd14;
    localparam logic [POS_W-1:0] POS_ID_HI    = 16'd18;
    localparam logic [POS_W-1:0] POS_ID_LO    = 16'd19;
    localparam logic [POS_W-1:0] POS_FRAG_HI  = 16'd20;
    localparam logic [POS_W-1:0] POS_FRAG_LO  = 16'd21;
    localparam logic [POS_W-1:0] POS_PROTO    = 16'd23;
    localparam logic [POS_W-1:0] POS_SRC_LO   = 16'd26;
    localparam logic [POS_W-1:0] POS_SRC_HI   = 16'd29;
    localparam logic [POS_W-1:0] POS_MAX      = 16'hFFFF;
    // last-byte positions below which a header is incomplete
    localparam logic [POS_W-1:0] RUNT_LAST    = 16'd13;
    localparam logic [POS_W-1:0] IP_MIN_LAST  = 16'd33;

    localparam logic [7:0] ETH_LEN   = 8'd14;
    localparam logic [7:0] UDP_LEN   = 8'd8;
    localparam logic [7:0] UDP_LAST  = 8'd7;   // UDP header complete at base + 7
    localparam logic [7:0] DNS_LAST  = 8'd19;  // DNS header complete at base + 19

    typedef logic [2:0] t_reason;
    localparam t_reason RSN_PASS = 3'd0;
    localparam t_reason RSN_RUNT = 3'd1;
    localparam t_reason RSN_IPV6 = 3'd2;
    localparam t_reason RSN_ZID  = 3'd3;
    localparam t_reason RSN_DF   = 3'd4;
    localparam t_reason RSN_AUTH = 3'd5;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [15:0]       ether_type;
        logic [3:0]        header_words;
        logic [7:0]        ip_protocol;
        logic [ADDR_W-1:0] ip_source;
        logic [15:0]       ip_ident;
        logic [15:0]       fragment_word;
        logic [PORT_W-1:0] udp_source_port;
        logic [15:0]       dns_flag_bytes;
        logic [15:0]       answer_count;
    } t_frame_state;

    localparam t_frame_state FRAME_CLEAR = '0;

endpackage

/* sv/dprf_if.sv */
// Interfaces: frame byte channel and verdict channel.
interface dprf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface dprf_verdict_if;
    logic       valid;
    logic       ready;
    logic       drop_frame;
    logic [2:0] verdict_reason;

    modport source (output valid, output drop_frame, output verdict_reason, input ready);
    modport sink   (input valid, input drop_frame, input verdict_reason, output ready);
endinterface

/* sv/dns_reply_poison_filter.sv */
// Top level: byte-stream DNS reply poison filter with registered verdict output.
//
//  channel     | dir | beat contents                    | notes
//  ------------+-----+----------------------------------+-----------------------------
//  i_frame     | in  | frame_byte[7:0], last_byte       | one frame byte per beat
//  o_verdict   | out | drop_frame, verdict_reason[2:0]  | one beat per frame, on last
//  i_cfg_*     | in  | index (0 addr, 1 port), data[31:0] | write-only, no wait states
//
// One byte per cycle sustained, unless a last byte waits on a stalled verdict. A beat is
// held in the input register, then the header capture and verdict logic settle from it
// into the frame state and, for a last byte, into the verdict register. Reset (synchronous,
// active low) clears the frame state, both valids and restores the filter address 8.8.8.8
// and port 53. A stalled verdict holds only a last byte in the input register; ordinary
// bytes keep flowing until the next frame's last byte arrives.
module dns_reply_poison_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dprf_byte_if.sink                   i_frame,
    dprf_verdict_if.source              o_verdict,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [dprf_pkg::CFG_W-1:0]  i_cfg_data
);
    import dprf_pkg::*;

    // configuration
    logic [ADDR_W-1:0] r_src_addr;
    logic [PORT_W-1:0] r_dns_port;

    // input register
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;

    // frame state and verdict register
    t_frame_state r_st, n_st;
    logic         r_out_valid;
    logic         r_out_drop, n_drop;
    t_reason      r_out_reason, n_reason;

    logic s1_adv;

    // a last byte needs the verdict register free; other bytes always move on
    assign s1_adv         = r_s1_valid && (!r_s1_last || !r_out_valid || o_verdict.ready);
    assign i_frame.ready  = !r_s1_valid || s1_adv;

    assign o_verdict.valid          = r_out_valid;
    assign o_verdict.drop_frame     = r_out_drop;
    assign o_verdict.verdict_reason = r_out_reason;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_addr <= SRC_ADDR_RESET;
            r_dns_port <= DNS_PORT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SRC_ADDR: r_src_addr <= i_cfg_data;
                CFG_DNS_PORT: r_dns_port <= i_cfg_data[PORT_W-1:0];
                default: ;
            endcase
        end
    end

    // header capture and verdict
    always_comb begin
        logic [7:0]       b;
        logic [POS_W-1:0] p;
        logic [7:0]       udp_base;
        logic [7:0]       dns_base;
        logic [POS_W-1:0] udp_pos;
        logic [POS_W-1:0] dns_pos;

        b    = r_s1_byte;
        p    = r_st.pos;
        n_st = r_st;

        if (p == POS_TYPE_HI)  n_st.ether_type[15:8]    = b;
        if (p == POS_TYPE_LO)  n_st.ether_type[7:0]     = b;
        if (p == POS_IHL)      n_st.header_words        = b[3:0];
        if (p == POS_ID_HI)    n_st.ip_ident[15:8]      = b;
        if (p == POS_ID_LO)    n_st.ip_ident[7:0]       = b;
        if (p == POS_FRAG_HI)  n_st.fragment_word[15:8] = b;
        if (p == POS_FRAG_LO)  n_st.fragment_word[7:0]  = b;
        if (p == POS_PROTO)    n_st.ip_protocol         = b;
        if (p >= POS_SRC_LO && p <= POS_SRC_HI)
            n_st.ip_source = {r_st.ip_source[ADDR_W-9:0], b};

        // UDP header follows the IP header; IHL of this very byte counts
        udp_base = ETH_LEN + {2'b00, n_st.header_words, 2'b00};
        dns_base = udp_base + UDP_LEN;
        udp_pos  = {8'h00, udp_base};
        dns_pos  = {8'h00, dns_base};
        if (p >= {8'h00, ETH_LEN}) begin
            if (p == udp_pos)          n_st.udp_source_port[15:8] = b;
            if (p == udp_pos + 16'd1)  n_st.udp_source_port[7:0]  = b;
            if (p == dns_pos + 16'd2)  n_st.dns_flag_bytes[15:8]  = b;
            if (p == dns_pos + 16'd3)  n_st.dns_flag_bytes[7:0]   = b;
            if (p == dns_pos + 16'd6)  n_st.answer_count[15:8]    = b;
            if (p == dns_pos + 16'd7)  n_st.answer_count[7:0]     = b;
        end

        // verdict, in priority order; length is p + 1
        n_drop   = 1'b0;
        n_reason = RSN_PASS;
        priority if (p < RUNT_LAST) begin
            n_drop = 1'b1; n_reason = RSN_RUNT;
        end else if (n_st.ether_type == TYPE_IPV6) begin
            n_drop = 1'b1; n_reason = RSN_IPV6;
        end else if (n_st.ether_type != TYPE_IPV4 || p < IP_MIN_LAST
                     || n_st.ip_protocol != PROTO_UDP || n_st.ip_source != r_src_addr) begin
            n_drop = 1'b0;
        end else if (n_st.ip_ident == 16'h0000) begin
            n_drop = 1'b1; n_reason = RSN_ZID;
        end else if (n_st.fragment_word == FRAG_DF_ONLY) begin
            n_drop = 1'b1; n_reason = RSN_DF;
        end else if (p < {8'h00, udp_base + UDP_LAST}
                     || n_st.udp_source_port != r_dns_port
                     || p < {8'h00, udp_base + DNS_LAST}
                     || !n_st.dns_flag_bytes[15]       // query
                     || n_st.dns_flag_bytes[5]         // AD set
                     || n_st.answer_count > 16'd1) begin
            n_drop = 1'b0;
        end else if (n_st.dns_flag_bytes[10]) begin   // AA set
            n_drop = 1'b1; n_reason = RSN_AUTH;
        end else begin
            n_drop = 1'b0;
        end

        if (r_s1_last) n_st = FRAME_CLEAR;
        else if (p != POS_MAX) n_st.pos = p + 16'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_st        <= FRAME_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (i_frame.ready) r_s1_valid <= i_frame.valid;
            if (s1_adv) r_st <= n_st;
            if (s1_adv && r_s1_last) r_out_valid <= 1'b1;
            else if (o_verdict.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.ready && i_frame.valid) begin
            r_s1_byte <= i_frame.frame_byte;
            r_s1_last <= i_frame.last_byte;
        end
        if (s1_adv && r_s1_last) begin
            r_out_drop   <= n_drop;
            r_out_reason <= n_reason;
        end
    end

    // a pass verdict never carries a reason
    a_pass_no_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_drop |-> r_out_reason == RSN_PASS)
        else $error("pass verdict with non-zero reason");

    // a drop verdict always names its reason
    a_drop_has_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_drop |-> r_out_reason != RSN_PASS)
        else $error("drop verdict without reason");

    // position restarts after a frame ends
    a_pos_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(s1_adv && r_s1_last) |-> r_st.pos == '0)
        else $error("frame state not cleared after last byte");

    // a last byte waiting on a stalled verdict is kept
    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_last && r_out_valid && !o_verdict.ready |=> r_s1_valid && r_s1_last)
        else $error("last byte lost while verdict stalled");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the DNS reply poison filter: frame beats in, verdicts checked.
`timescale 1ns / 100ps

module tb_top;
    import dprf_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 50_000;
    localparam int unsigned SETTLE_CYCLES = 8;    // input, then verdict register
    localparam int unsigned LONG_HOLD     = 400;

    // DNS flag word bits
    localparam int unsigned QR_BIT = 15;
    localparam int unsigned AA_BIT = 10;
    localparam int unsigned AD_BIT = 5;

    typedef struct packed {
        logic    drop;
        t_reason reason;
    } verdict_t;

    // what a generated frame carries; bytes not named here are random
    typedef struct {
        int unsigned len;
        logic [15:0] etype;
        logic [7:0]  vihl;
        logic [15:0] ident;
        logic [15:0] frag;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [15:0] sport;
        logic [15:0] flags;
        logic [15:0] answers;
    } frame_knobs_t;

    // Tracks the filter's header capture byte by byte and holds the verdicts owed.
    class verdict_ledger;
        logic [ADDR_W-1:0] src_addr;
        logic [PORT_W-1:0] dns_port;
        t_frame_state      frame;
        verdict_t          due[$];
        int unsigned       faults;

        function new();
            src_addr = SRC_ADDR_RESET;
            dns_port = DNS_PORT_RESET;
            frame    = FRAME_CLEAR;
            faults   = 0;
        endfunction

        function void set_register(logic idx, logic [CFG_W-1:0] d);
            if (idx == CFG_SRC_ADDR) begin
                src_addr = d;
            end else begin
                dns_port = d[PORT_W-1:0];
            end
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            logic [POS_W-1:0] p;
            logic [POS_W-1:0] ub;
            verdict_t         v;
            p = frame.pos;
            if (p == POS_TYPE_HI) frame.ether_type[15:8] = b;
            if (p == POS_TYPE_LO) frame.ether_type[7:0] = b;
            if (p == POS_IHL) frame.header_words = b[3:0];
            if (p == POS_ID_HI) frame.ip_ident[15:8] = b;
            if (p == POS_ID_LO) frame.ip_ident[7:0] = b;
            if (p == POS_FRAG_HI) frame.fragment_word[15:8] = b;
            if (p == POS_FRAG_LO) frame.fragment_word[7:0] = b;
            if (p == POS_PROTO) frame.ip_protocol = b;
            if (p >= POS_SRC_LO && p <= POS_SRC_HI) frame.ip_source = {frame.ip_source[23:0], b};

            // UDP follows the IP header as IHL says, even if that overlaps it (IHL < 5)
            ub = 16'(ETH_LEN) + {10'd0, frame.header_words, 2'b00};
            if (p >= 16'(ETH_LEN)) begin
                if (p == ub)      frame.udp_source_port[15:8] = b;
                if (p == ub + 1)  frame.udp_source_port[7:0]  = b;
                if (p == ub + 10) frame.dns_flag_bytes[15:8]  = b;
                if (p == ub + 11) frame.dns_flag_bytes[7:0]   = b;
                if (p == ub + 14) frame.answer_count[15:8]    = b;
                if (p == ub + 15) frame.answer_count[7:0]     = b;
            end

            if (!last) begin
                if (frame.pos != POS_MAX) frame.pos = frame.pos + 1'b1;   // saturates
                return;
            end

            // decision order matters: earlier checks mask later ones
            if (p < RUNT_LAST) begin
                v = {1'b1, RSN_RUNT};
            end else if (frame.ether_type == TYPE_IPV6) begin
                v = {1'b1, RSN_IPV6};
            end else if (frame.ether_type != TYPE_IPV4 || p < IP_MIN_LAST
                         || frame.ip_protocol != PROTO_UDP || frame.ip_source != src_addr) begin
                v = {1'b0, RSN_PASS};
            end else if (frame.ip_ident == '0) begin
                v = {1'b1, RSN_ZID};
            end else if (frame.fragment_word == FRAG_DF_ONLY) begin
                v = {1'b1, RSN_DF};
            end else if (p < ub + UDP_LAST || frame.udp_source_port != dns_port
                         || p < ub + DNS_LAST || !frame.dns_flag_bytes[QR_BIT]
                         || frame.dns_flag_bytes[AD_BIT] || frame.answer_count > 16'd1) begin
                v = {1'b0, RSN_PASS};
            end else if (frame.dns_flag_bytes[AA_BIT]) begin
                v = {1'b1, RSN_AUTH};
            end else begin
                v = {1'b0, RSN_PASS};
            end
            due.push_back(v);
            frame = FRAME_CLEAR;
        endfunction

        function void check_verdict(logic drop, t_reason reason);
            verdict_t want;
            if (due.size() == 0) begin
                $error("verdict beat with none owed: drop_frame %0b verdict_reason %0d",
                       drop, reason);
                faults++;
                return;
            end
            want = due.pop_front();
            if (drop !== want.drop) begin
                $error("drop_frame: expected %0b, actual %0b", want.drop, drop);
                faults++;
            end
            if (reason !== want.reason) begin
                $error("verdict_reason: expected %0d, actual %0d", want.reason, reason);
                faults++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    dprf_byte_if    frame_if();
    dprf_verdict_if verdict_if();

    verdict_ledger ledger;
    bit            idle_sender   = 1'b1;
    bit            idle_receiver = 1'b1;
    bit            long_hold     = 1'b0;
    int unsigned   cycle_count   = 0;

    dns_reply_poison_filter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame     (frame_if),
        .o_verdict   (verdict_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // An authoritative reply from the configured server: drops unless altered or IHL < 5.
    function automatic frame_knobs_t reply_knobs(int unsigned ihl, int unsigned payload);
        frame_knobs_t k;
        k.len     = 34 + 4 * ihl + payload;
        k.etype   = TYPE_IPV4;
        k.vihl    = {4'h4, 4'(ihl)};
        k.ident   = 16'($urandom_range(1, 16'hFFFF));
        k.frag    = 16'h0000;
        k.proto   = PROTO_UDP;
        k.src     = ledger.src_addr;
        k.sport   = ledger.dns_port;
        k.flags   = 16'($urandom) & 16'h7BDF;     // QR, AA and AD cleared ...
        k.flags[QR_BIT] = 1'b1;
        k.flags[AA_BIT] = 1'b1;                   // ... then reply + authoritative
        k.answers = 16'd1;
        return k;
    endfunction

    // Mostly well-formed replies with every field nudged now and then; some noise.
    function automatic frame_knobs_t random_knobs();
        frame_knobs_t k;
        int unsigned  roll;
        k = reply_knobs(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 5,
                        $urandom_range(0, 24));
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            k.len   = $urandom_range(1, 80);
            k.etype = ($urandom_range(0, 1) == 0) ? TYPE_IPV4 : 16'($urandom);
            k.vihl  = 8'($urandom);
            k.ident = 16'($urandom);
            k.frag  = 16'($urandom);
            k.proto = 8'($urandom);
            k.sport = 16'($urandom);
            k.flags = 16'($urandom);
            k.answers = 16'($urandom);
            return k;
        end
        if (roll < 16) begin
            k.etype = TYPE_IPV6;
        end else if (roll < 19) begin
            k.etype = 16'($urandom);
        end
        if ($urandom_range(0, 15) == 0) k.vihl[7:4] = 4'($urandom);
        if ($urandom_range(0, 9) == 0) k.ident = '0;
        case ($urandom_range(0, 9))
            0:       k.frag = FRAG_DF_ONLY;
            1:       k.frag = 16'($urandom);
            default: k.frag = 16'h0000;
        endcase
        if ($urandom_range(0, 11) == 0) k.proto = 8'($urandom);
        case ($urandom_range(0, 11))
            0:       k.src = 32'($urandom);
            1:       k.src = ledger.src_addr ^ (32'd1 << $urandom_range(0, 31));
            default: k.src = ledger.src_addr;
        endcase
        case ($urandom_range(0, 11))
            0:       k.sport = 16'($urandom);
            1:       k.sport = ledger.dns_port ^ (16'd1 << $urandom_range(0, 15));
            default: k.sport = ledger.dns_port;
        endcase
        k.flags = 16'($urandom);
        if ($urandom_range(0, 6) != 0) k.flags[QR_BIT] = 1'b1;
        if ($urandom_range(0, 4) != 0) k.flags[AD_BIT] = 1'b0;
        case ($urandom_range(0, 7))
            0, 7:    k.answers = 16'd0;
            4:       k.answers = 16'd2;
            5:       k.answers = 16'h0100;        // caught only if ANCOUNT is read big-endian
            6:       k.answers = 16'($urandom);
            default: k.answers = 16'd1;
        endcase
        if ($urandom_range(0, 5) == 0) k.len = $urandom_range(1, k.len);
        return k;
    endfunction

    // Byte i of the frame. IP fields win where a short IHL makes UDP/DNS overlap them.
    function automatic logic [7:0] byte_at(frame_knobs_t k, int unsigned i);
        int unsigned ub;
        ub = 14 + 4 * k.vihl[3:0];
        case (i)
            POS_TYPE_HI: return k.etype[15:8];
            POS_TYPE_LO: return k.etype[7:0];
            POS_IHL:     return k.vihl;
            POS_ID_HI:   return k.ident[15:8];
            POS_ID_LO:   return k.ident[7:0];
            POS_FRAG_HI: return k.frag[15:8];
            POS_FRAG_LO: return k.frag[7:0];
            POS_PROTO:   return k.proto;
            default: ;
        endcase
        if (i >= POS_SRC_LO && i <= POS_SRC_HI) return k.src[8 * (POS_SRC_HI - i) +: 8];
        if (i == ub)      return k.sport[15:8];
        if (i == ub + 1)  return k.sport[7:0];
        if (i == ub + 10) return k.flags[15:8];   // DNS header starts at ub + 8
        if (i == ub + 11) return k.flags[7:0];
        if (i == ub + 14) return k.answers[15:8];
        if (i == ub + 15) return k.answers[7:0];
        return 8'($urandom);
    endfunction

    // One beat; returns at the edge where it was taken, valid still high.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_sender && $urandom_range(0, 7) == 0) begin
            frame_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        frame_if.valid      <= 1'b1;
        frame_if.frame_byte <= b;
        frame_if.last_byte  <= last;
        @(posedge i_clk);
        while (!frame_if.ready) @(posedge i_clk);
    endtask

    task automatic send_frame(input frame_knobs_t k);
        for (int unsigned i = 0; i < k.len; i++) send_byte(byte_at(k, i), i == k.len - 1);
    endtask

    task automatic random_frames(input int unsigned min_bytes, input int unsigned min_frames);
        frame_knobs_t k;
        int unsigned  n_bytes;
        int unsigned  n_frames;
        n_bytes  = 0;
        n_frames = 0;
        while (n_bytes < min_bytes || n_frames < min_frames) begin
            k = random_knobs();
            send_frame(k);
            n_bytes += k.len;
            n_frames++;
        end
    endtask

    // Stop offering, wait for every owed verdict, then let the pipe empty.
    task automatic settle();
        frame_if.valid <= 1'b0;
        while (ledger.due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Both registers back to back, write enable held across the pair.
    task automatic set_filter(input logic [CFG_W-1:0] addr, input logic [CFG_W-1:0] port);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SRC_ADDR;
        i_cfg_data  <= addr;
        @(posedge i_clk);
        i_cfg_index <= CFG_DNS_PORT;
        i_cfg_data  <= port;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ledger.set_register(CFG_SRC_ADDR, addr);
        ledger.set_register(CFG_DNS_PORT, port);
    endtask

    // Verdict back-pressure: random bursts, plus one long hold on request.
    initial begin
        verdict_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                verdict_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (idle_receiver && $urandom_range(0, 5) == 0) begin
                verdict_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            verdict_if.ready <= 1'b1;
        end
    end

    // Both channels sampled at the edge, before anything driven there lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (frame_if.valid && frame_if.ready)
                ledger.take_byte(frame_if.frame_byte, frame_if.last_byte);
            if (verdict_if.valid && verdict_if.ready)
                ledger.check_verdict(verdict_if.drop_frame, verdict_if.verdict_reason);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("dns_reply_poison_filter regression: fail");
        $finish;
    end

    initial begin
        frame_knobs_t k;
        ledger = new();
        frame_if.valid      <= 1'b0;
        frame_if.frame_byte <= 8'h00;
        frame_if.last_byte  <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_SRC_ADDR;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames against the reset filter (8.8.8.8, port 53)
        k = reply_knobs(5, 0);  k.len = 1;   send_frame(k);     // single-byte runt
        k.len = 13;                          send_frame(k);     // longest runt
        k.len = 14;                          send_frame(k);     // type only, no IP header
        k.etype = TYPE_IPV6;                 send_frame(k);
        k.etype = 16'hFFFF;                  send_frame(k);     // foreign type passes
        k = reply_knobs(5, 0);  k.len = 33;  send_frame(k);     // IP header a byte short
        k.ident = '0;           k.len = 34;  send_frame(k);     // zero id at minimum length
        k = reply_knobs(5, 0);  k.len = 34;  k.proto = 8'd6;           send_frame(k);
        k = reply_knobs(5, 0);  k.len = 34;  k.src = ~ledger.src_addr; send_frame(k);
        k = reply_knobs(5, 0);  k.len = 34;  k.frag = FRAG_DF_ONLY;    send_frame(k);
        k.ident = '0;                                      send_frame(k);  // zero id ranks first
        k = reply_knobs(5, 0);  k.frag = 16'hFFFF;         send_frame(k);  // not DF-only
        k = reply_knobs(5, 0);  k.len = 41;                send_frame(k);  // UDP header short
        k = reply_knobs(5, 0);  k.sport = ~ledger.dns_port; send_frame(k);
        k = reply_knobs(5, 0);  k.len = 53;                send_frame(k);  // DNS header short
        k.len = 54;                                        send_frame(k);  // just complete
        k = reply_knobs(5, 0);  k.flags[QR_BIT] = 1'b0;    send_frame(k);  // query
        k = reply_knobs(5, 0);  k.flags[AD_BIT] = 1'b1;    send_frame(k);
        k = reply_knobs(5, 0);  k.answers = 16'h0100;      send_frame(k);
        k = reply_knobs(5, 0);  k.flags[AA_BIT] = 1'b0;    send_frame(k);
        k = reply_knobs(0, 0);                             send_frame(k);  // UDP over IHL byte
        settle();

        set_filter(32'h0000_0000, 32'h0000_0000);
        random_frames(40, 1);
        settle();

        // upper half of the port word must be ignored; verdicts held off for a while
        set_filter(32'hFFFF_FFFF, 32'hA5A5_FFFF);
        long_hold = 1'b1;
        random_frames(80, 2);
        settle();

        set_filter(32'($urandom), 32'($urandom));
        random_frames(40, 1);
        settle();

        // last stretch flat out on both sides
        set_filter(SRC_ADDR_RESET, {16'h0000, DNS_PORT_RESET});
        idle_sender   = 1'b0;
        idle_receiver = 1'b0;
        random_frames(80, 2);
        settle();

        if (ledger.faults == 0 && ledger.due.size() == 0) begin
            $display("dns_reply_poison_filter regression: pass");
        end else begin
            $display("dns_reply_poison_filter regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
sv/dprf_pkg.sv
sv/dprf_if.sv
sv/dns_reply_poison_filter.sv
tb/tb_top.sv
